FILE: src/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types and constants of the diagonal similarity run detector.
// ----------------------------------------------------------------------------
package dsr_pkg;

	localparam int MaxRepeats  = 4096;
	localparam int MaxAlignLen = 4096;

	localparam int CharW   = 8;
	localparam int VarW    = 24;
	localparam int CfgIdxW = 2;
	localparam int PosW    = $clog2(MaxRepeats);
	localparam int CntW    = $clog2(MaxAlignLen) + 1;
	localparam int CfgW    = (CntW > PosW + 1) ? CntW : PosW + 1;
	// similar flag, pair mismatches, both positions, last pair flag
	localparam int EvW     = 2*PosW + CntW + 2;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_MIN_RUN   = 2'd1,
		CFG_MODE      = 2'd2
	} cfg_idx_t;

endpackage

FILE: src/dsr_if.sv
// ----------------------------------------------------------------------------
// dsr_in_if / dsr_out_if
// Valid/ready channels for character items in and run records out.
// ----------------------------------------------------------------------------
interface dsr_in_if;
	import dsr_pkg::*;

	logic             valid;
	logic             ready;
	logic [CharW-1:0] a_char;
	logic [CharW-1:0] b_char;
	logic             dir_a;
	logic             dir_b;
	logic [PosW-1:0]  pos_a;
	logic [PosW-1:0]  pos_b;
	logic             last_char;
	logic             last_pair;

	modport source (
		output valid, a_char, b_char, dir_a, dir_b, pos_a, pos_b, last_char, last_pair,
		input  ready
	);
	modport sink (
		input  valid, a_char, b_char, dir_a, dir_b, pos_a, pos_b, last_char, last_pair,
		output ready
	);
endinterface

interface dsr_out_if;
	import dsr_pkg::*;

	logic            valid;
	logic            ready;
	logic [PosW:0]   start_a;
	logic [PosW:0]   end_a;
	logic [PosW:0]   start_b;
	logic [PosW:0]   end_b;
	logic            orientation;
	logic [VarW-1:0] variant_total;

	modport source (
		output valid, start_a, end_a, start_b, end_b, orientation, variant_total,
		input  ready
	);
	modport sink (
		input  valid, start_a, end_a, start_b, end_b, orientation, variant_total,
		output ready
	);
endinterface

FILE: src/dsr_front.sv
// ----------------------------------------------------------------------------
// dsr_front
// Accepts character items, counts mismatches per pair and classifies each
// finished pair as similar or not; pushes one event per pair.
// ----------------------------------------------------------------------------
module dsr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	dsr_in_if.sink                    in_ch,
	input  logic [dsr_pkg::CntW-1:0]  threshold,
	input  logic                      antiparallel,
	input  logic                      q_ready,
	output logic                      push,
	output logic [dsr_pkg::EvW-1:0]   push_data
);
	import dsr_pkg::*;

	logic [CntW-1:0] pair_cnt_q;
	logic [CntW-1:0] pm;
	logic            bump;
	logic            accept;
	logic            dir_ok;
	logic            similar;

	assign in_ch.ready = q_ready;
	assign accept      = in_ch.valid && q_ready;

	assign bump    = (in_ch.a_char != in_ch.b_char) && (pair_cnt_q != {CntW{1'b1}});
	assign pm      = pair_cnt_q + CntW'(bump);
	assign dir_ok  = antiparallel ? (in_ch.dir_a != in_ch.dir_b) : (in_ch.dir_a == in_ch.dir_b);
	assign similar = dir_ok && (pm <= threshold);

	assign push      = accept && in_ch.last_char;
	assign push_data = {similar, pm, in_ch.pos_a, in_ch.pos_b, in_ch.last_pair};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_cnt_q <= '0;
		end else if (accept) begin
			// restart the count once the pair closes
			pair_cnt_q <= in_ch.last_char ? '0 : pm;
		end
	end

endmodule

FILE: src/dsr_queue.sv
// ----------------------------------------------------------------------------
// dsr_queue
// Two-entry event queue between the front and the back.
// ----------------------------------------------------------------------------
module dsr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [dsr_pkg::EvW-1:0] push_data,
	output logic                    push_ready,
	input  logic                    pop,
	output logic                    pop_valid,
	output logic [dsr_pkg::EvW-1:0] pop_data
);
	import dsr_pkg::*;

	logic [EvW-1:0] entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

FILE: src/dsr_back.sv
// ----------------------------------------------------------------------------
// dsr_back
// Tracks the open run along the diagonal and loads a run record into the
// output register when a run closes long enough.
// ----------------------------------------------------------------------------
module dsr_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ev_valid,
	input  logic [dsr_pkg::EvW-1:0]   ev_data,
	output logic                      ev_pop,
	input  logic [dsr_pkg::PosW:0]    min_run,
	input  logic                      antiparallel,
	dsr_out_if.source                 out_ch
);
	import dsr_pkg::*;

	localparam int LenW = PosW + 1;

	logic             ev_similar;
	logic [CntW-1:0]  ev_pm;
	logic [PosW-1:0]  ev_pa;
	logic [PosW-1:0]  ev_pb;
	logic             ev_lastp;

	logic [LenW-1:0]  len_q;
	logic [VarW-1:0]  var_q;
	logic [PosW-1:0]  sa_q;
	logic [PosW-1:0]  sb_q;
	logic [PosW-1:0]  lb_q;

	logic             out_valid_q;
	logic [LenW-1:0]  start_a_q;
	logic [LenW-1:0]  end_a_q;
	logic [LenW-1:0]  start_b_q;
	logic [LenW-1:0]  end_b_q;
	logic             orient_q;
	logic [VarW-1:0]  vtot_q;

	logic             run_open;
	logic [LenW-1:0]  new_len;
	logic [VarW:0]    var_sum;
	logic [VarW-1:0]  new_var;
	logic [PosW-1:0]  new_sa;
	logic [PosW-1:0]  new_sb;
	logic [LenW-1:0]  sel_len;
	logic [VarW-1:0]  sel_var;
	logic [PosW-1:0]  sel_sa;
	logic [PosW-1:0]  sel_sb;
	logic [PosW-1:0]  sel_lb;
	logic [PosW+1:0]  ea_sum;
	logic [LenW-1:0]  ea;
	logic [LenW-1:0]  sb_one;
	logic [LenW-1:0]  lb_one;
	logic             emit;

	assign {ev_similar, ev_pm, ev_pa, ev_pb, ev_lastp} = ev_data;

	assign ev_pop = ev_valid && (!out_valid_q || out_ch.ready);

	assign run_open = (len_q != '0);
	assign new_len  = !run_open ? LenW'(1) :
	                  (len_q == {LenW{1'b1}}) ? len_q : len_q + LenW'(1);
	assign var_sum  = {1'b0, var_q} + (VarW+1)'(ev_pm);
	assign new_var  = !run_open ? VarW'(ev_pm) :
	                  var_sum[VarW] ? {VarW{1'b1}} : var_sum[VarW-1:0];
	assign new_sa   = run_open ? sa_q : ev_pa;
	assign new_sb   = run_open ? sb_q : ev_pb;

	// A similar closing pair reports the updated run, a dissimilar one the old run
	assign sel_len = ev_similar ? new_len : len_q;
	assign sel_var = ev_similar ? new_var : var_q;
	assign sel_sa  = ev_similar ? new_sa : sa_q;
	assign sel_sb  = ev_similar ? new_sb : sb_q;
	assign sel_lb  = ev_similar ? ev_pb : lb_q;

	assign ea_sum = {2'b00, sel_sa} + {1'b0, sel_len};
	assign ea     = ea_sum[PosW+1] ? {LenW{1'b1}} : ea_sum[LenW-1:0];
	assign sb_one = {1'b0, sel_sb} + LenW'(1);
	assign lb_one = {1'b0, sel_lb} + LenW'(1);

	assign emit = ev_similar ? (ev_lastp && (new_len >= min_run)) :
	              (run_open && (len_q >= min_run));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			var_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
			lb_q  <= '0;
		end else if (ev_pop) begin
			if (ev_similar) begin
				sa_q <= new_sa;
				sb_q <= new_sb;
				lb_q <= ev_pb;
				// drop the run at the end of the diagonal
				len_q <= ev_lastp ? '0 : new_len;
				var_q <= ev_lastp ? '0 : new_var;
			end else begin
				len_q <= '0;
				var_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ev_pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pop && emit) begin
			start_a_q <= {1'b0, sel_sa} + LenW'(1);
			end_a_q   <= ea;
			start_b_q <= antiparallel ? lb_one : sb_one;
			end_b_q   <= antiparallel ? sb_one : lb_one;
			orient_q  <= antiparallel;
			vtot_q    <= sel_var;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.start_a       = start_a_q;
	assign out_ch.end_a         = end_a_q;
	assign out_ch.start_b       = start_b_q;
	assign out_ch.end_b         = end_b_q;
	assign out_ch.orientation   = orient_q;
	assign out_ch.variant_total = vtot_q;

endmodule

FILE: src/diagonal_similarity_run_detector.sv
// A result passes through the event queue, then the run tracker into the
//   output register, after the item that closes its run is accepted.
// Throughput: one item per cycle while the event queue has room; the front
//   counts mismatches, the back updates the run once per pair event.
// Reset: clears counters, the open run and the queue; threshold 0,
//   shortest run 1, parallel mode.
// ----------------------------------------------------------------------------
// diagonal_similarity_run_detector
// Top level: configuration registers, front classifier, event queue and
// run tracker.
// ----------------------------------------------------------------------------
module diagonal_similarity_run_detector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dsr_pkg::CfgIdxW-1:0]           cfg_index,
	input  logic [dsr_pkg::CfgW-1:0]              cfg_data,
	dsr_in_if.sink                                in_ch,
	dsr_out_if.source                             out_ch
);
	import dsr_pkg::*;

	logic [CntW-1:0] threshold_q;
	logic [PosW:0]   min_run_q;
	logic            mode_q;

	logic            push;
	logic [EvW-1:0]  push_data;
	logic            q_ready;
	logic            ev_valid;
	logic [EvW-1:0]  ev_data;
	logic            ev_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			min_run_q   <= (PosW+1)'(1);
			mode_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: threshold_q <= cfg_data[CntW-1:0];
				CFG_MIN_RUN:   min_run_q   <= cfg_data[PosW:0];
				CFG_MODE:      mode_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	dsr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.threshold    (threshold_q),
		.antiparallel (mode_q),
		.q_ready      (q_ready),
		.push         (push),
		.push_data    (push_data)
	);

	dsr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (q_ready),
		.pop        (ev_pop),
		.pop_valid  (ev_valid),
		.pop_data   (ev_data)
	);

	dsr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (ev_valid),
		.ev_data      (ev_data),
		.ev_pop       (ev_pop),
		.min_run      (min_run_q),
		.antiparallel (mode_q),
		.out_ch       (out_ch)
	);

`ifndef SYNTHESIS
	// a closed pair always leaves an event behind for the back
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.last_char) |=> ev_valid)
		else $error("pair event lost on its way to the queue");

	// a run covers at least one pair on side A
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.start_a <= out_ch.end_a))
		else $error("run record with end_a below start_a");

	// the back only takes events that exist
	assert property (@(posedge clk) disable iff (!arst_n)
		ev_pop |-> ev_valid)
		else $error("event popped from an empty queue");
`endif

endmodule
